[design/tfn_pkg.sv]
package tfn_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned EdgeW  = 25;
  localparam int unsigned ProdW  = 50;
  localparam int unsigned RawW   = 50;
  localparam int unsigned MagW   = 49;
  localparam int unsigned LoW    = 32;
  localparam int unsigned HiW    = 17;
  localparam int unsigned SqW    = 98;
  localparam int unsigned SumW   = 100;
  localparam int unsigned ResW   = 136;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned Axes   = 3;
  localparam int unsigned RootStages = 16;

  localparam logic [UnitW-1:0] UnitPosMax = 16'h7FFF;

  typedef struct packed {
    logic [Axes-1:0][ResW-1:0]  rem;
    logic [Axes-1:0][ResW-1:0]  g;
    logic [Axes-1:0][UnitW-1:0] m;
    logic [SumW-1:0]            s;
    logic [Axes-1:0][RawW-1:0]  raw;
    logic                       degen;
  } tfn_search_t;

endpackage

[design/tfn_root_stage.sv]
module tfn_root_stage #(
  parameter int unsigned Bit = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tfn_pkg::tfn_search_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tfn_pkg::tfn_search_t out_data
);

  logic                 valid_r;
  tfn_pkg::tfn_search_t data_r;
  tfn_pkg::tfn_search_t data_nxt;
  logic signed [tfn_pkg::ResW-1:0] sh_g  [tfn_pkg::Axes];
  logic signed [tfn_pkg::ResW-1:0] trial [tfn_pkg::Axes];
  logic signed [tfn_pkg::ResW-1:0] s_ext;
  logic signed [tfn_pkg::ResW-1:0] sh_s;
  logic signed [tfn_pkg::ResW-1:0] add_g;

  assign in_stall  = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt = in_data;
    s_ext    = signed'({{(tfn_pkg::ResW - tfn_pkg::SumW){1'b0}}, in_data.s});
    sh_s     = s_ext <<< (2 * Bit + 2);
    add_g    = s_ext <<< (Bit + 1);
    for (int c = 0; c < tfn_pkg::Axes; c++) begin
      sh_g[c]  = signed'(in_data.g[c]) <<< (Bit + 2);
      trial[c] = signed'(in_data.rem[c]) - sh_g[c] - sh_s;
      if (!trial[c][tfn_pkg::ResW-1]) begin
        data_nxt.rem[c]  = trial[c];
        data_nxt.g[c]    = signed'(in_data.g[c]) + add_g;
        data_nxt.m[c][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      data_r <= data_nxt;
    end
  end

endmodule

[design/triangle_face_normal_unit.sv]
// Face normal of one triangle per request. The raw normal is the exact cross
// product of the edges p1 - p0 and p2 - p0; the unit normal is that vector
// scaled to length one in Q1.15, rounded to nearest with ties away from zero,
// and a zero cross product gives a zero unit normal with degenerate set. The
// block takes one triangle every cycle unless a stall from the result side
// holds the pipeline. Seven stages form the edges, products and squared
// length; sixteen stages then find one bit of all three unit components
// each, and a last stage applies sign and saturation.
module triangle_face_normal_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_p0_x,
  input  logic signed [23:0] in_p0_y,
  input  logic signed [23:0] in_p0_z,
  input  logic signed [23:0] in_p1_x,
  input  logic signed [23:0] in_p1_y,
  input  logic signed [23:0] in_p1_z,
  input  logic signed [23:0] in_p2_x,
  input  logic signed [23:0] in_p2_y,
  input  logic signed [23:0] in_p2_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [49:0] out_raw_x,
  output logic signed [49:0] out_raw_y,
  output logic signed [49:0] out_raw_z,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic signed [15:0] out_unit_z,
  output logic               out_degenerate
);

  localparam int unsigned Front = 7;

  logic [Front-1:0] valid_r;
  logic [Front-1:0] stage_in_v;
  logic [Front:0]   go;

  logic signed [tfn_pkg::CoordW-1:0] p0 [tfn_pkg::Axes];
  logic signed [tfn_pkg::CoordW-1:0] p1 [tfn_pkg::Axes];
  logic signed [tfn_pkg::CoordW-1:0] p2 [tfn_pkg::Axes];

  logic signed [tfn_pkg::EdgeW-1:0] e2_r [tfn_pkg::Axes];
  logic signed [tfn_pkg::EdgeW-1:0] e0_r [tfn_pkg::Axes];
  logic signed [tfn_pkg::ProdW-1:0] pa_r [tfn_pkg::Axes];
  logic signed [tfn_pkg::ProdW-1:0] pb_r [tfn_pkg::Axes];
  logic signed [tfn_pkg::RawW-1:0]  raw_c_r [tfn_pkg::Axes];
  logic                             degen_c_r;
  logic signed [tfn_pkg::RawW-1:0]  raw_d_r [tfn_pkg::Axes];
  logic                             degen_d_r;
  logic [2*tfn_pkg::LoW-1:0]          ll_r [tfn_pkg::Axes];
  logic [tfn_pkg::LoW+tfn_pkg::HiW-1:0] lh_r [tfn_pkg::Axes];
  logic [2*tfn_pkg::HiW-1:0]          hh_r [tfn_pkg::Axes];
  logic signed [tfn_pkg::RawW-1:0]  raw_e_r [tfn_pkg::Axes];
  logic                             degen_e_r;
  logic [tfn_pkg::SqW-1:0]          sq_e_r [tfn_pkg::Axes];
  logic signed [tfn_pkg::RawW-1:0]  raw_f_r [tfn_pkg::Axes];
  logic                             degen_f_r;
  logic [tfn_pkg::SqW-1:0]          sq_f_r [tfn_pkg::Axes];
  logic [tfn_pkg::SumW-1:0]         sum_f_r;
  tfn_pkg::tfn_search_t             init_r;
  tfn_pkg::tfn_search_t             init_nxt;

  logic [tfn_pkg::MagW-1:0] mag [tfn_pkg::Axes];
  logic [tfn_pkg::RawW-1:0] neg [tfn_pkg::Axes];

  tfn_pkg::tfn_search_t srch_d [tfn_pkg::RootStages+1];
  logic                 srch_v [tfn_pkg::RootStages+1];
  logic                 srch_s [tfn_pkg::RootStages+1];

  logic                             out_valid_r;
  logic signed [tfn_pkg::RawW-1:0]  out_raw_r  [tfn_pkg::Axes];
  logic signed [tfn_pkg::UnitW-1:0] out_unit_r [tfn_pkg::Axes];
  logic signed [tfn_pkg::UnitW-1:0] unit_nxt   [tfn_pkg::Axes];
  logic                             out_degen_r;
  logic                             out_take;

  assign p0[0] = in_p0_x;
  assign p0[1] = in_p0_y;
  assign p0[2] = in_p0_z;
  assign p1[0] = in_p1_x;
  assign p1[1] = in_p1_y;
  assign p1[2] = in_p1_z;
  assign p2[0] = in_p2_x;
  assign p2[1] = in_p2_y;
  assign p2[2] = in_p2_z;

  assign go[Front] = !srch_s[0];
  for (genvar i = 0; i < Front; i++) begin : g_go
    assign go[i] = !valid_r[i] || go[i+1];
  end
  assign stage_in_v = {valid_r[Front-2:0], in_valid};
  assign in_stall   = !go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < Front; i++) begin
        if (go[i]) begin
          valid_r[i] <= stage_in_v[i];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < tfn_pkg::Axes; c++) begin
      neg[c] = raw_c_r[c][tfn_pkg::RawW-1] ? tfn_pkg::RawW'(-raw_c_r[c])
                                           : tfn_pkg::RawW'(raw_c_r[c]);
      mag[c] = neg[c][tfn_pkg::MagW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      for (int c = 0; c < tfn_pkg::Axes; c++) begin
        e2_r[c] <= tfn_pkg::EdgeW'(p1[c]) - tfn_pkg::EdgeW'(p0[c]);
        e0_r[c] <= tfn_pkg::EdgeW'(p2[c]) - tfn_pkg::EdgeW'(p0[c]);
      end
    end
    if (go[1]) begin
      pa_r[0] <= e2_r[1] * e0_r[2];
      pb_r[0] <= e2_r[2] * e0_r[1];
      pa_r[1] <= e2_r[2] * e0_r[0];
      pb_r[1] <= e2_r[0] * e0_r[2];
      pa_r[2] <= e2_r[0] * e0_r[1];
      pb_r[2] <= e2_r[1] * e0_r[0];
    end
    if (go[2]) begin
      for (int c = 0; c < tfn_pkg::Axes; c++) begin
        raw_c_r[c] <= pa_r[c] - pb_r[c];
      end
      degen_c_r <= (pa_r[0] == pb_r[0]) && (pa_r[1] == pb_r[1]) && (pa_r[2] == pb_r[2]);
    end
    if (go[3]) begin
      for (int c = 0; c < tfn_pkg::Axes; c++) begin
        raw_d_r[c] <= raw_c_r[c];
        ll_r[c] <= mag[c][tfn_pkg::LoW-1:0] * mag[c][tfn_pkg::LoW-1:0];
        lh_r[c] <= mag[c][tfn_pkg::LoW-1:0] * mag[c][tfn_pkg::MagW-1:tfn_pkg::LoW];
        hh_r[c] <= mag[c][tfn_pkg::MagW-1:tfn_pkg::LoW] *
                   mag[c][tfn_pkg::MagW-1:tfn_pkg::LoW];
      end
      degen_d_r <= degen_c_r;
    end
    if (go[4]) begin
      for (int c = 0; c < tfn_pkg::Axes; c++) begin
        raw_e_r[c] <= raw_d_r[c];
        sq_e_r[c]  <= tfn_pkg::SqW'(ll_r[c]) + (tfn_pkg::SqW'(lh_r[c]) << (tfn_pkg::LoW + 1))
                    + (tfn_pkg::SqW'(hh_r[c]) << (2 * tfn_pkg::LoW));
      end
      degen_e_r <= degen_d_r;
    end
    if (go[5]) begin
      for (int c = 0; c < tfn_pkg::Axes; c++) begin
        raw_f_r[c] <= raw_e_r[c];
        sq_f_r[c]  <= sq_e_r[c];
      end
      sum_f_r <= tfn_pkg::SumW'(sq_e_r[0]) + tfn_pkg::SumW'(sq_e_r[1])
               + tfn_pkg::SumW'(sq_e_r[2]);
      degen_f_r <= degen_e_r;
    end
    if (go[6]) begin
      init_r <= init_nxt;
    end
  end

  always_comb begin
    init_nxt       = '0;
    init_nxt.s     = sum_f_r;
    init_nxt.degen = degen_f_r;
    for (int c = 0; c < tfn_pkg::Axes; c++) begin
      init_nxt.raw[c] = raw_f_r[c];
      init_nxt.rem[c] = (tfn_pkg::ResW'(sq_f_r[c]) << tfn_pkg::LoW) - tfn_pkg::ResW'(sum_f_r);
      init_nxt.g[c]   = tfn_pkg::ResW'(0) - tfn_pkg::ResW'(sum_f_r);
    end
  end

  assign srch_d[0] = init_r;
  assign srch_v[0] = valid_r[Front-1];

  for (genvar j = 0; j < tfn_pkg::RootStages; j++) begin : g_root
    tfn_root_stage #(
      .Bit(tfn_pkg::RootStages - 1 - j)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (srch_v[j]),
      .in_stall (srch_s[j]),
      .in_data  (srch_d[j]),
      .out_valid(srch_v[j+1]),
      .out_stall(srch_s[j+1]),
      .out_data (srch_d[j+1])
    );
  end

  assign out_take = !(out_valid_r && out_stall);
  assign srch_s[tfn_pkg::RootStages] = !out_take;

  always_comb begin
    for (int c = 0; c < tfn_pkg::Axes; c++) begin
      if (srch_d[tfn_pkg::RootStages].degen) begin
        unit_nxt[c] = '0;
      end else if (srch_d[tfn_pkg::RootStages].raw[c][tfn_pkg::RawW-1]) begin
        unit_nxt[c] = ~srch_d[tfn_pkg::RootStages].m[c] + 16'd1;
      end else if (srch_d[tfn_pkg::RootStages].m[c][tfn_pkg::UnitW-1]) begin
        unit_nxt[c] = tfn_pkg::UnitPosMax;
      end else begin
        unit_nxt[c] = srch_d[tfn_pkg::RootStages].m[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= srch_v[tfn_pkg::RootStages];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      for (int c = 0; c < tfn_pkg::Axes; c++) begin
        out_raw_r[c]  <= srch_d[tfn_pkg::RootStages].raw[c];
        out_unit_r[c] <= unit_nxt[c];
      end
      out_degen_r <= srch_d[tfn_pkg::RootStages].degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_raw_x      = out_raw_r[0];
  assign out_raw_y      = out_raw_r[1];
  assign out_raw_z      = out_raw_r[2];
  assign out_unit_x     = out_unit_r[0];
  assign out_unit_y     = out_unit_r[1];
  assign out_unit_z     = out_unit_r[2];
  assign out_degenerate = out_degen_r;

`ifndef ASSERT_OFF
  a_degen_zero_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_raw_x == '0 && out_raw_y == '0 && out_raw_z == '0)
    else $error("degenerate flag with nonzero raw normal");

  a_degen_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0)
    else $error("degenerate result with nonzero unit normal");

  a_sign_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_raw_x[49] |-> !out_unit_x[15])
    else $error("unit x sign disagrees with raw x");

  a_zero_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate && out_raw_x == '0 |-> out_unit_x == '0)
    else $error("unit x nonzero for zero raw x");
`endif

endmodule
